@@ hw/rtl/s2cd_pkg.sv @@
// Shared constants, types and tables for the seconds-to-calendar-date pipeline.
// Used by seconds_to_calendar_date and its port checker; depends on nothing.

package s2cd_pkg;

  // Default width of the seconds count
  localparam int unsigned SECONDS_BITS_DEF = 40;

  // Result fields, lowest bits first in m_axis_tdata
  localparam int unsigned YEAR_W     = 16;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned MDAY_W     = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned SEC_W      = 6;
  localparam int unsigned WDAY_W     = 3;
  localparam int unsigned YDAY_W     = 9;
  localparam int unsigned OUT_DATA_W = 56;

  // Seconds within a day, day within a 400-year era, day within a March-based year
  localparam int unsigned SOD_W = 17;
  localparam int unsigned DOE_W = 18;
  localparam int unsigned YOE_W = 9;
  localparam int unsigned DOY_W = 9;
  localparam int unsigned MP_W  = 4;

  // Reciprocals: floor(x / d) as (x * RECIP) >> SHIFT
  // Seconds / 128 / 675 gives days; estimate may be one low and is corrected.
  localparam int unsigned  DAY_SHIFT  = 41;
  localparam logic [31:0]  RECIP_675  = 32'((64'd1 << DAY_SHIFT) / 64'd675);
  // Days / 146097 gives 400-year eras; estimate may be one low and is corrected.
  localparam int unsigned  ERA_SHIFT  = 49;
  localparam logic [31:0]  RECIP_ERA  = 32'((64'd1 << ERA_SHIFT) / 64'd146097);
  // Exact over the ranges in use
  localparam int unsigned  HOUR_SHIFT = 29;
  localparam logic [17:0]  RECIP_HOUR = 18'd149131;
  localparam int unsigned  MIN_SHIFT  = 18;
  localparam logic [12:0]  RECIP_MIN  = 13'd4370;
  localparam int unsigned  Q1460_SHIFT = 28;
  localparam int unsigned  Q365_SHIFT  = 26;
  localparam logic [17:0]  RECIP_1460 = 18'd183860;
  localparam logic [17:0]  RECIP_365  = 18'd183860;

  // Days from 0000-03-01 to 1970-01-01, and days in a 400-year era
  localparam logic [19:0]  DAYS_TO_EPOCH = 20'd719468;
  localparam logic [17:0]  DAYS_PER_ERA  = 18'd146097;
  localparam logic [15:0]  YEAR_BASE     = 16'd1900;

  // Time of day and weekday, carried alongside the date path
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [WDAY_W-1:0] wday;
  } tod_t;

  // First day of each month in a year that starts on March 1
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] start;
    case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

@@ hw/rtl/seconds_to_calendar_date.sv @@
// Seconds-since-1970 to Gregorian date and time of day, fourteen-stage pipeline.
// Depends on s2cd_pkg for constants, the month table and the time-of-day type.
//
// Usage:
//   Slave channel s_axis_* carries one seconds count per request (low
//   SECONDS_BITS bits of tdata, higher bits ignored). Master channel m_axis_*
//   returns one packed date per request, in request order.
// Depth and throughput:
//   A request accepted at one edge passes through every stage in order before it
//   shows on m_axis_tvalid. One request is taken every cycle while the output is
//   not stalled. The depth is set by the date path: reciprocal multiplies for
//   whole days, 400-year eras and the year of the era, then the month search.
// Reset:
//   rst_ni clears every stage valid bit at once; payload registers keep junk
//   that is never shown. The block is ready right after reset.
// Stall:
//   While the last stage holds a result that is not taken, the whole pipeline
//   holds and s_axis_tready is low in the same cycle. Nothing is lost or
//   repeated; empty slots do not collapse.

module seconds_to_calendar_date #(
  parameter  int unsigned SECONDS_BITS = s2cd_pkg::SECONDS_BITS_DEF,
  localparam int unsigned InDataW      = ((SECONDS_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request: epoch_seconds
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [InDataW-1:0]                s_axis_tdata,
  // Result: years_since_1900, month_index, day_of_month, hour_of_day,
  //   minute_of_hour, second_of_minute, weekday, day_of_year, zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [s2cd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned NStg  = 14;
  localparam int unsigned XW    = SECONDS_BITS - 7;
  localparam int unsigned XLoW  = 20;
  localparam int unsigned XHiW  = XW - XLoW;
  localparam int unsigned PHiW  = XHiW + 32;
  localparam int unsigned PLoW  = XLoW + 32;
  localparam int unsigned SumW  = XW + 32;
  localparam int unsigned DayW  = SECONDS_BITS - 16;
  localparam int unsigned ZW    = (DayW > 22) ? DayW : 22;
  localparam int unsigned PZW   = ZW + 32;
  localparam int unsigned EraW  = ZW - 17;
  localparam int unsigned NDig  = (DayW + 2) / 3;
  localparam int unsigned WsumW = $clog2(7 * NDig + 5);

  localparam int unsigned DoeW = s2cd_pkg::DOE_W;
  localparam int unsigned DoyW = s2cd_pkg::DOY_W;
  localparam int unsigned YoeW = s2cd_pkg::YOE_W;
  localparam int unsigned MpW  = s2cd_pkg::MP_W;
  localparam int unsigned YrW  = s2cd_pkg::YEAR_W;

  // ---------------------------------------------------------------- control
  logic [NStg-1:0] vld_q;
  logic            en;

  // Advance every stage unless the last one holds an untaken result
  assign en            = !vld_q[NStg-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Split seconds/128 into a high and a low part and multiply each by the reciprocal of 675
  logic [XW-1:0]    x_in;
  logic [PHiW-1:0]  s1_phi_d, s1_phi_q;
  logic [PLoW-1:0]  s1_plo_d, s1_plo_q;
  logic [10:0]      s1_xlo_q;
  logic [6:0]       s1_tlo_q;

  assign x_in     = s_axis_tdata[SECONDS_BITS-1:7];
  assign s1_phi_d = PHiW'(x_in[XW-1:XLoW]) * PHiW'(s2cd_pkg::RECIP_675);
  assign s1_plo_d = PLoW'(x_in[XLoW-1:0]) * PLoW'(s2cd_pkg::RECIP_675);

  // ---------------------------------------------------------------- stage 2
  // Sum partial products into the day estimate
  logic [SumW-1:0]  s2_sum;
  logic [DayW-1:0]  s2_q0_d, s2_q0_q;
  logic [10:0]      s2_xlo_q;
  logic [6:0]       s2_tlo_q;

  assign s2_sum  = (SumW'(s1_phi_q) << XLoW) + SumW'(s1_plo_q);
  assign s2_q0_d = s2_sum[s2cd_pkg::DAY_SHIFT +: DayW];

  // ---------------------------------------------------------------- stage 3
  // Fix the estimate from the low remainder bits; rebuild seconds of day
  logic [10:0]               s3_r0;
  logic                      s3_up;
  logic [10:0]               s3_r;
  logic [DayW-1:0]           s3_days_d, s3_days_q;
  logic [s2cd_pkg::SOD_W-1:0] s3_secs_d, s3_secs_q;

  assign s3_r0     = s2_xlo_q - 11'(s2_q0_q[10:0] * 11'd675);
  assign s3_up     = s3_r0 >= 11'd675;
  assign s3_r      = s3_up ? (s3_r0 - 11'd675) : s3_r0;
  assign s3_days_d = s2_q0_q + DayW'(s3_up);
  assign s3_secs_d = {s3_r[9:0], s2_tlo_q};

  // ---------------------------------------------------------------- stage 4
  // Shift the day count to March 0000, take the hour, sum octal digits for weekday
  logic [ZW-1:0]              s4_z_d, s4_z_q;
  logic [34:0]                s4_hprod;
  logic [s2cd_pkg::HOUR_W-1:0] s4_hour_d, s4_hour_q;
  logic [s2cd_pkg::SOD_W-1:0]  s4_secs_q;
  logic [3*NDig-1:0]          s4_dpad;
  logic [WsumW-1:0]           s4_wsum_d, s4_wsum_q;

  assign s4_z_d    = ZW'(s3_days_q) + ZW'(s2cd_pkg::DAYS_TO_EPOCH);
  assign s4_hprod  = 35'(s3_secs_q) * 35'(s2cd_pkg::RECIP_HOUR);
  assign s4_hour_d = s4_hprod[s2cd_pkg::HOUR_SHIFT +: s2cd_pkg::HOUR_W];
  assign s4_dpad   = (3 * NDig)'(s3_days_q);

  always_comb begin
    s4_wsum_d = '0;
    for (int i = 0; i < NDig; i++) begin
      s4_wsum_d = s4_wsum_d + WsumW'(s4_dpad[3*i +: 3]);
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Era estimate; seconds within the hour; fold the digit sum to a weekday
  logic [PZW-1:0]              s5_pz;
  logic [EraW-1:0]             s5_era_d, s5_era_q;
  logic [18:0]                 s5_z19_q;
  logic [11:0]                 s5_rem_d, s5_rem_q;
  logic [s2cd_pkg::HOUR_W-1:0] s5_hour_q;
  logic [6:0]                  s5_x7;
  logic [3:0]                  s5_f1, s5_f2;
  logic [s2cd_pkg::WDAY_W-1:0] s5_wday_d, s5_wday_q;

  assign s5_pz    = PZW'(s4_z_q) * PZW'(s2cd_pkg::RECIP_ERA);
  assign s5_era_d = s5_pz[s2cd_pkg::ERA_SHIFT +: EraW];
  assign s5_rem_d = 12'(s4_secs_q - 17'(17'(s4_hour_q) * 17'd3600));
  assign s5_x7    = 7'(s4_wsum_q) + 7'd4;
  assign s5_f1    = 4'(s5_x7[2:0]) + 4'(s5_x7[5:3]) + 4'(s5_x7[6]);
  assign s5_f2    = 4'(s5_f1[2:0]) + 4'(s5_f1[3]);
  assign s5_wday_d = (s5_f2 >= 4'd7) ? 3'(s5_f2 - 4'd7) : s5_f2[2:0];

  // ---------------------------------------------------------------- stage 6
  // Day within the era before correction; minute of the hour
  logic [18:0]                 s6_doe_d, s6_doe_q;
  logic [EraW-1:0]             s6_era_q;
  logic [24:0]                 s6_mprod;
  logic [s2cd_pkg::MIN_W-1:0]  s6_min_d, s6_min_q;
  logic [11:0]                 s6_rem_q;
  logic [s2cd_pkg::HOUR_W-1:0] s6_hour_q;
  logic [s2cd_pkg::WDAY_W-1:0] s6_wday_q;

  assign s6_doe_d = s5_z19_q - 19'(19'(s5_era_q) * 19'(s2cd_pkg::DAYS_PER_ERA));
  assign s6_mprod = 25'(s5_rem_q) * 25'(s2cd_pkg::RECIP_MIN);
  assign s6_min_d = s6_mprod[s2cd_pkg::MIN_SHIFT +: s2cd_pkg::MIN_W];

  // ---------------------------------------------------------------- stage 7
  // Correct the era; second of the minute
  logic                 s7_up;
  logic [DoeW-1:0]      s7_doe_d, s7_doe_q;
  logic [EraW-1:0]      s7_era_d, s7_era_q;
  s2cd_pkg::tod_t       s7_tod_d;

  assign s7_up    = s6_doe_q >= 19'(s2cd_pkg::DAYS_PER_ERA);
  assign s7_doe_d = s7_up ? DoeW'(s6_doe_q - 19'(s2cd_pkg::DAYS_PER_ERA)) : DoeW'(s6_doe_q);
  assign s7_era_d = s6_era_q + EraW'(s7_up);

  always_comb begin
    s7_tod_d.hour   = s6_hour_q;
    s7_tod_d.minute = s6_min_q;
    s7_tod_d.second = 6'(s6_rem_q - 12'(12'(s6_min_q) * 12'd60));
    s7_tod_d.wday   = s6_wday_q;
  end

  // ---------------------------------------------------------------- stage 8
  // Leap-day corrections within the era: doe/1460, doe/36524, doe/146096
  logic [35:0]     s8_aprod;
  logic [6:0]      s8_a_d, s8_a_q;
  logic [2:0]      s8_b_d, s8_b_q;
  logic            s8_c_d, s8_c_q;
  logic [YrW-1:0]  s8_era400_d, s8_era400_q;
  logic [DoeW-1:0] s8_doe_q;

  assign s8_aprod    = 36'(s7_doe_q) * 36'(s2cd_pkg::RECIP_1460);
  assign s8_a_d      = s8_aprod[s2cd_pkg::Q1460_SHIFT +: 7];
  assign s8_c_d      = s7_doe_q == 18'd146096;
  assign s8_era400_d = YrW'(YrW'(s7_era_q) * 16'd400);

  always_comb begin
    s8_b_d = '0;
    for (int k = 1; k < 5; k++) begin
      if (s7_doe_q >= 18'(k * 36524)) begin
        s8_b_d = s8_b_d + 3'd1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 9
  // Day count with leap days taken out
  logic [DoeW-1:0] s9_n_d, s9_n_q;
  logic [DoeW-1:0] s9_doe_q;
  logic [YrW-1:0]  s9_era400_q;

  assign s9_n_d = s8_doe_q - DoeW'(s8_a_q) + DoeW'(s8_b_q) - DoeW'(s8_c_q);

  // ---------------------------------------------------------------- stage 10
  // Year of the era
  logic [35:0]     s10_yprod;
  logic [YoeW-1:0] s10_yoe_d, s10_yoe_q;
  logic [DoeW-1:0] s10_doe_q;
  logic [YrW-1:0]  s10_era400_q;

  assign s10_yprod = 36'(s9_n_q) * 36'(s2cd_pkg::RECIP_365);
  assign s10_yoe_d = s10_yprod[s2cd_pkg::Q365_SHIFT +: YoeW];

  // ---------------------------------------------------------------- stage 11
  // Days before this March-based year; leap flag of its calendar year
  logic [1:0]      s11_cent;
  logic [DoeW-1:0] s11_base_d, s11_base_q;
  logic            s11_leap_d, s11_leap_q;
  logic [YoeW-1:0] s11_yoe_q;
  logic [DoeW-1:0] s11_doe_q;
  logic [YrW-1:0]  s11_era400_q;

  assign s11_cent   = 2'(s10_yoe_q >= 9'd100) + 2'(s10_yoe_q >= 9'd200)
                    + 2'(s10_yoe_q >= 9'd300);
  assign s11_base_d = DoeW'(s10_yoe_q) * 18'd365 + DoeW'(s10_yoe_q >> 2) - DoeW'(s11_cent);
  assign s11_leap_d = (s10_yoe_q[1:0] == 2'd0) && (s10_yoe_q != 9'd100)
                   && (s10_yoe_q != 9'd200) && (s10_yoe_q != 9'd300);

  // ---------------------------------------------------------------- stage 12
  // Day within the March-based year
  logic [DoyW-1:0] s12_doy_d, s12_doy_q;
  logic [YoeW-1:0] s12_yoe_q;
  logic            s12_leap_q;
  logic [YrW-1:0]  s12_era400_q;

  assign s12_doy_d = DoyW'(s11_doe_q - s11_base_q);

  // ---------------------------------------------------------------- stage 13
  // Month search: count month starts at or below the day
  logic [MpW-1:0]  s13_mp_d, s13_mp_q;
  logic [DoyW-1:0] s13_doy_q;
  logic [YoeW-1:0] s13_yoe_q;
  logic            s13_leap_q;
  logic [YrW-1:0]  s13_era400_q;

  always_comb begin
    s13_mp_d = '0;
    for (int k = 1; k < 12; k++) begin
      if (s12_doy_q >= s2cd_pkg::month_start(MpW'(k))) begin
        s13_mp_d = s13_mp_d + 4'd1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 14
  // Map to January-based month, day of year and calendar year
  logic                         s14_jan;
  logic [YrW-1:0]               s14_year_d, s14_year_q;
  logic [s2cd_pkg::MONTH_W-1:0] s14_month_d, s14_month_q;
  logic [s2cd_pkg::MDAY_W-1:0]  s14_mday_d, s14_mday_q;
  logic [s2cd_pkg::YDAY_W-1:0]  s14_yday_d, s14_yday_q;

  assign s14_jan     = s13_mp_q >= 4'd10;
  assign s14_mday_d  = 5'(s13_doy_q - s2cd_pkg::month_start(s13_mp_q) + 9'd1);
  assign s14_month_d = s14_jan ? (s13_mp_q - 4'd10) : (s13_mp_q + 4'd2);
  assign s14_yday_d  = s14_jan ? (s13_doy_q - 9'd306)
                               : (s13_doy_q + 9'd59 + 9'(s13_leap_q));
  assign s14_year_d  = s13_era400_q + YrW'(s13_yoe_q) + YrW'(s14_jan)
                     - s2cd_pkg::YEAR_BASE;

  // Time of day travels beside the date path
  s2cd_pkg::tod_t tod_q [7:NStg];

  // ---------------------------------------------------------------- payload
  // Advance all payload registers together with the valid bits
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_phi_q     <= s1_phi_d;
      s1_plo_q     <= s1_plo_d;
      s1_xlo_q     <= x_in[10:0];
      s1_tlo_q     <= s_axis_tdata[6:0];

      s2_q0_q      <= s2_q0_d;
      s2_xlo_q     <= s1_xlo_q;
      s2_tlo_q     <= s1_tlo_q;

      s3_days_q    <= s3_days_d;
      s3_secs_q    <= s3_secs_d;

      s4_z_q       <= s4_z_d;
      s4_hour_q    <= s4_hour_d;
      s4_secs_q    <= s3_secs_q;
      s4_wsum_q    <= s4_wsum_d;

      s5_era_q     <= s5_era_d;
      s5_z19_q     <= s4_z_q[18:0];
      s5_rem_q     <= s5_rem_d;
      s5_hour_q    <= s4_hour_q;
      s5_wday_q    <= s5_wday_d;

      s6_doe_q     <= s6_doe_d;
      s6_era_q     <= s5_era_q;
      s6_min_q     <= s6_min_d;
      s6_rem_q     <= s5_rem_q;
      s6_hour_q    <= s5_hour_q;
      s6_wday_q    <= s5_wday_q;

      s7_doe_q     <= s7_doe_d;
      s7_era_q     <= s7_era_d;
      tod_q[7]     <= s7_tod_d;

      s8_a_q       <= s8_a_d;
      s8_b_q       <= s8_b_d;
      s8_c_q       <= s8_c_d;
      s8_era400_q  <= s8_era400_d;
      s8_doe_q     <= s7_doe_q;

      s9_n_q       <= s9_n_d;
      s9_doe_q     <= s8_doe_q;
      s9_era400_q  <= s8_era400_q;

      s10_yoe_q    <= s10_yoe_d;
      s10_doe_q    <= s9_doe_q;
      s10_era400_q <= s9_era400_q;

      s11_base_q   <= s11_base_d;
      s11_leap_q   <= s11_leap_d;
      s11_yoe_q    <= s10_yoe_q;
      s11_doe_q    <= s10_doe_q;
      s11_era400_q <= s10_era400_q;

      s12_doy_q    <= s12_doy_d;
      s12_yoe_q    <= s11_yoe_q;
      s12_leap_q   <= s11_leap_q;
      s12_era400_q <= s11_era400_q;

      s13_mp_q     <= s13_mp_d;
      s13_doy_q    <= s12_doy_q;
      s13_yoe_q    <= s12_yoe_q;
      s13_leap_q   <= s12_leap_q;
      s13_era400_q <= s12_era400_q;

      s14_year_q   <= s14_year_d;
      s14_month_q  <= s14_month_d;
      s14_mday_q   <= s14_mday_d;
      s14_yday_q   <= s14_yday_d;

      for (int i = 8; i <= NStg; i++) begin
        tod_q[i] <= tod_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign m_axis_tdata = {2'b00,
                         s14_yday_q,
                         tod_q[NStg].wday,
                         tod_q[NStg].second,
                         tod_q[NStg].minute,
                         tod_q[NStg].hour,
                         s14_mday_q,
                         s14_month_q,
                         s14_year_q};

endmodule

@@ hw/rtl/s2cd_checker.sv @@
// Port-level checks for seconds_to_calendar_date, attached by bind.
// Depends on s2cd_pkg for the result width.

module s2cd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [s2cd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [3:0] month;
  logic [4:0] mday;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [2:0] wday;
  logic [8:0] yday;

  // Unpack result fields
  assign month  = m_axis_tdata[19:16];
  assign mday   = m_axis_tdata[24:20];
  assign hour   = m_axis_tdata[29:25];
  assign minute = m_axis_tdata[35:30];
  assign second = m_axis_tdata[41:36];
  assign wday   = m_axis_tdata[44:42];
  assign yday   = m_axis_tdata[53:45];

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Take a request whenever the output slot is free
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused with empty output");

  // Keep month, time of day, weekday and day of year in range, and day of month at least 1
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> month <= 4'd11 && mday >= 5'd1 && hour <= 5'd23
      && minute <= 6'd59 && second <= 6'd59 && wday <= 3'd6 && yday <= 9'd365)
    else $error("result field out of range");

  // Drop day 31 in thirty-day months
  a_short_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (month == 4'd3 || month == 4'd5 || month == 4'd8 || month == 4'd10)
      |-> mday <= 5'd30)
    else $error("day 31 in a thirty-day month");

  // Match day of year to day of month in January, checked only while s_axis_tvalid is high
  a_january: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && month == 4'd0 && s_axis_tvalid |-> yday == 9'(mday) - 9'd1)
    else $error("January day of year mismatch");

endmodule

bind seconds_to_calendar_date s2cd_checker u_s2cd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
